// File: rtl/odcd_pkg.sv
// shared types, status codes and calendar table for the ordinal date decoder
package odcd_pkg;

  localparam logic [1:0] STATUS_RAW     = 2'd0;
  localparam logic [1:0] STATUS_NEVER   = 2'd1;
  localparam logic [1:0] STATUS_DECODED = 2'd2;

  localparam logic [7:0]  EBCDIC_NINE  = 8'hF9;
  localparam logic [3:0]  EBCDIC_ZONE  = 4'hF;
  localparam logic [11:0] BASE_YEAR    = 12'd2000;
  localparam logic [8:0]  DAYS_COMMON  = 9'd365;
  localparam logic [8:0]  DAYS_LEAP    = 9'd366;
  localparam int          NUM_MONTHS   = 12;

  typedef struct packed {
    logic [47:0] date_bytes;
    logic [3:0]  byte_count;
    logic        is_expiration;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [11:0] year;
    logic [8:0]  ordinal_day;
    logic [3:0]  month;
    logic [4:0]  day_of_month;
  } out_item_t;

  // first stage result: checks done, numbers assembled
  typedef struct packed {
    logic        never;
    logic        well_formed;
    logic        leap;
    logic [11:0] year;
    logic [9:0]  doy;
  } field_t;

  // second stage result: range checked, month picked
  typedef struct packed {
    logic [1:0]  status;
    logic [11:0] year;
    logic [8:0]  doy;
    logic [3:0]  month;
    logic [8:0]  days_before;
  } split_t;

  // days before the first of month m (1..12)
  function automatic logic [8:0] days_before_month(input logic [3:0] m, input logic leap);
    logic [8:0] base;
    begin
      case (m)
        4'd1:    base = 9'd0;
        4'd2:    base = 9'd31;
        4'd3:    base = 9'd59;
        4'd4:    base = 9'd90;
        4'd5:    base = 9'd120;
        4'd6:    base = 9'd151;
        4'd7:    base = 9'd181;
        4'd8:    base = 9'd212;
        4'd9:    base = 9'd243;
        4'd10:   base = 9'd273;
        4'd11:   base = 9'd304;
        4'd12:   base = 9'd334;
        default: base = 9'd0;
      endcase
      if (leap && m >= 4'd3) begin
        base = base + 9'd1;
      end
      return base;
    end
  endfunction

endpackage

// File: rtl/odcd_field_decode.sv
// digit checks, sentinel detection and year/day assembly for one field
module odcd_field_decode (
  input  odcd_pkg::in_item_t item,
  output odcd_pkg::field_t   field
);
  import odcd_pkg::*;

  logic [7:0]  b [6];
  logic [3:0]  dig [6];
  logic [5:0]  is_digit;
  logic        all_nine;
  logic [6:0]  yy;
  logic [11:0] year;
  logic [9:0]  doy;

  always_comb begin
    for (int k = 0; k < 6; k++) begin
      b[k]        = item.date_bytes[47 - 8*k -: 8];
      dig[k]      = b[k][3:0];
      is_digit[k] = (b[k][7:4] == EBCDIC_ZONE) && (b[k][3:0] <= 4'd9);
    end
    all_nine = 1'b1;
    for (int k = 0; k < 5; k++) begin
      if (b[k] != EBCDIC_NINE) begin
        all_nine = 1'b0;
      end
    end
    yy   = 7'(dig[1]) * 7'd10 + 7'(dig[2]);
    year = BASE_YEAR + 12'(dig[0]) * 12'd100 + 12'(yy);
    // three digits reach 999, so the day needs ten bits before the range check
    doy  = 10'(dig[3]) * 10'd100 + 10'(dig[4]) * 10'd10 + 10'(dig[5]);

    field.never       = item.is_expiration && (item.byte_count == 4'd5) && all_nine;
    field.well_formed = (item.byte_count == 4'd6) && (&is_digit);
    // century years are leap only when 20+c is a multiple of four
    field.leap        = (yy == 7'd0) ? (dig[0][1:0] == 2'd0) : (yy[1:0] == 2'd0);
    field.year        = year;
    field.doy         = doy;
  end

endmodule

// File: rtl/ordinal_date_to_calendar_decoder_core.sv
// top level: three stage ordinal date to calendar date decoder
// an accepted input beat passes the s1, s2 and s3 registers in order to become the result beat
// throughput: one beat per cycle; each stage holds while the next is full and stalled
// reset clears the stage valid bits only, payload registers are left as they are
module ordinal_date_to_calendar_decoder_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  odcd_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output odcd_pkg::out_item_t out_item
);
  import odcd_pkg::*;

  logic      v1, v2, v3;
  logic      en1, en2, en3;
  field_t    field_next;
  field_t    s1;
  split_t    s2, s2_next;
  out_item_t s3, s3_next;
  logic [8:0] max_day;
  logic [3:0] month;
  logic       decoded;

  assign en3      = !v3 || !out_stall;
  assign en2      = !v2 || en3;
  assign en1      = !v1 || en2;
  assign in_stall = !en1;

  odcd_field_decode u_decode (
    .item  (in_item),
    .field (field_next)
  );

  // stage two: range check and month pick
  always_comb begin
    max_day = s1.leap ? DAYS_LEAP : DAYS_COMMON;
    decoded = s1.well_formed && (s1.doy != 10'd0) && (s1.doy <= 10'(max_day));
    month   = 4'd1;
    for (int m = 2; m <= NUM_MONTHS; m++) begin
      if (s1.doy > 10'(days_before_month(4'(m), s1.leap))) begin
        month = 4'(m);
      end
    end
    s2_next.status      = s1.never ? STATUS_NEVER : (decoded ? STATUS_DECODED : STATUS_RAW);
    s2_next.year        = s1.year;
    s2_next.doy         = s1.doy[8:0];
    s2_next.month       = month;
    s2_next.days_before = days_before_month(month, s1.leap);
  end

  // stage three: day of month, blank fields unless decoded
  always_comb begin
    s3_next.status = s2.status;
    if (s2.status == STATUS_DECODED) begin
      s3_next.year         = s2.year;
      s3_next.ordinal_day  = s2.doy;
      s3_next.month        = s2.month;
      s3_next.day_of_month = 5'(s2.doy - s2.days_before);
    end else begin
      s3_next.year         = '0;
      s3_next.ordinal_day  = '0;
      s3_next.month        = '0;
      s3_next.day_of_month = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (en1) v1 <= in_valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) s1 <= field_next;
    if (en2) s2 <= s2_next;
    if (en3) s3 <= s3_next;
  end

  assign out_valid = v3;
  assign out_item  = s3;

endmodule
